FILE: hw/rtl/lbdi_pkg.sv
// Shared types and constants for the laser blanking dwell inserter.
`timescale 1ns / 1ps
`default_nettype none
package lbdi_pkg;

  localparam int unsigned MaxDwell     = 63;
  localparam int unsigned ColorBits    = 16;
  localparam int unsigned BlankFlagBit = 0;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ColorW = 16;
  localparam int unsigned FlagsW = 8;
  localparam int unsigned DwellW = 6;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 104;

  localparam logic [CountW-1:0] LimitReset = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEAD_IN  = 2'd0,
    CFG_LEAD_OUT = 2'd1,
    CFG_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAD_IN,
    ST_POINT,
    ST_LEAD_OUT
  } state_e;

  typedef enum logic [1:0] {
    EMIT_LEAD_IN,
    EMIT_POINT,
    EMIT_LEAD_OUT
  } emit_kind_e;

  typedef struct packed {
    logic       load;
    logic       emit;
    emit_kind_e kind;
    logic       last;
    logic       dwell_dec;
    logic       dwell_load_out;
  } lbdi_cmd_t;

  typedef struct packed {
    logic full;
    logic limit_hit;
    logic dwell_zero;
    logic dwell_one;
    logic no_lead_out;
    logic out_free;
  } lbdi_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lbdi_ctrl.sv
// Controller state machine sequencing lead-in, point and lead-out emission.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire lbdi_pkg::lbdi_status_t st_i,
  output lbdi_pkg::lbdi_cmd_t    cmd_o
);
  import lbdi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LEAD_IN;
      end
      ST_LEAD_IN: begin
        if (st_i.full) begin
          state_d = ST_IDLE;
        end else if (st_i.dwell_zero) begin
          state_d = ST_POINT;
        end else if (cmd_o.emit && cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_POINT: begin
        if (st_i.full) begin
          state_d = ST_IDLE;
        end else if (cmd_o.emit) begin
          state_d = cmd_o.last ? ST_IDLE : ST_LEAD_OUT;
        end
      end
      ST_LEAD_OUT: begin
        if (st_i.full || st_i.dwell_zero) begin
          state_d = ST_IDLE;
        end else if (cmd_o.emit && cmd_o.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = EMIT_POINT;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LEAD_IN: begin
        cmd_o.kind = EMIT_LEAD_IN;
        if (!st_i.full && !st_i.dwell_zero && st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.last      = st_i.limit_hit;
          cmd_o.dwell_dec = 1'b1;
        end
      end
      ST_POINT: begin
        cmd_o.kind = EMIT_POINT;
        if (!st_i.full && st_i.out_free) begin
          cmd_o.emit           = 1'b1;
          cmd_o.last           = st_i.limit_hit || st_i.no_lead_out;
          cmd_o.dwell_load_out = 1'b1;
        end
      end
      ST_LEAD_OUT: begin
        cmd_o.kind = EMIT_LEAD_OUT;
        if (!st_i.full && !st_i.dwell_zero && st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.last      = st_i.limit_hit || st_i.dwell_one;
          cmd_o.dwell_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LEAD_IN))
    else $error("accepted request did not start a run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("run continued after its last result");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (st_i.out_free && !st_i.full))
    else $error("emit without output room or past the frame limit");

endmodule
`default_nettype wire

FILE: hw/rtl/lbdi_datapath.sv
// Datapath: config registers, point hold, dwell counter, frame count and output register.
`timescale 1ns / 1ps
`default_nettype none
module lbdi_datapath #(
  parameter int unsigned MAX_DWELL      = lbdi_pkg::MaxDwell,
  parameter int unsigned COLOR_BITS     = lbdi_pkg::ColorBits,
  parameter int unsigned BLANK_FLAG_BIT = lbdi_pkg::BlankFlagBit
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [lbdi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [lbdi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire  [lbdi_pkg::InDataW-1:0]   in_data_i,
  input  wire                            in_frame_start_i,
  input  wire lbdi_pkg::lbdi_cmd_t       cmd_i,
  output lbdi_pkg::lbdi_status_t         st_o,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [lbdi_pkg::OutDataW-1:0]  out_data_o,
  output logic                           out_last_o
);
  import lbdi_pkg::*;

  localparam logic [ColorW-1:0] ColorMask = ColorW'((32'd1 << COLOR_BITS) - 32'd1);
  localparam logic [FlagsW-1:0] BlankMask = FlagsW'(32'd1 << BLANK_FLAG_BIT);
  localparam logic [DwellW-1:0] DwellCap  = DwellW'(MAX_DWELL);

  logic [DwellW-1:0] lead_in_q, lead_out_q;
  logic [CountW-1:0] limit_q;

  logic signed [CoordW-1:0] x_q, y_q;
  logic [ColorW-1:0]        r_q, g_q, b_q;
  logic [FlagsW-1:0]        fl_q;
  logic                     trans_off_q;
  logic                     prev_blank_q;
  logic [CountW-1:0]        count_q;
  logic [DwellW-1:0]        dwell_q;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] ox_q, oy_q;
  logic [ColorW-1:0]        or_q, og_q, ob_q;
  logic [FlagsW-1:0]        ofl_q;
  logic [CountW-1:0]        opos_q;
  logic                     olast_q;

  logic [ColorW-1:0] in_r, in_g, in_b;
  logic [FlagsW-1:0] in_fl;
  logic              cur_blank, prev_eff, trans_on, trans_off;
  logic [DwellW-1:0] n_in, n_out;
  logic [CountW-1:0] count_inc;

  assign in_r  = in_data_i[47:32] & ColorMask;
  assign in_g  = in_data_i[63:48] & ColorMask;
  assign in_b  = in_data_i[79:64] & ColorMask;
  assign in_fl = in_data_i[87:80];

  assign cur_blank = in_fl[BLANK_FLAG_BIT] || ((in_r | in_g | in_b) == '0);
  assign prev_eff  = in_frame_start_i || prev_blank_q;
  assign trans_on  = prev_eff && !cur_blank;
  assign trans_off = !prev_eff && cur_blank;

  assign n_in  = (lead_in_q > DwellCap) ? DwellCap : lead_in_q;
  assign n_out = (lead_out_q > DwellCap) ? DwellCap : lead_out_q;

  assign count_inc = count_q + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_in_q  <= '0;
      lead_out_q <= '0;
      limit_q    <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LEAD_IN:  lead_in_q  <= cfg_data_i[DwellW-1:0];
        CFG_LEAD_OUT: lead_out_q <= cfg_data_i[DwellW-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= in_data_i[15:0];
      y_q  <= in_data_i[31:16];
      r_q  <= in_r;
      g_q  <= in_g;
      b_q  <= in_b;
      fl_q <= in_fl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_off_q  <= 1'b0;
      prev_blank_q <= 1'b1;
      count_q      <= '0;
      dwell_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        trans_off_q  <= trans_off;
        prev_blank_q <= cur_blank;
        dwell_q      <= trans_on ? n_in : '0;
        if (in_frame_start_i) count_q <= '0;
      end else begin
        if (cmd_i.emit) count_q <= count_inc;
        if (cmd_i.dwell_dec) begin
          dwell_q <= dwell_q - DwellW'(1);
        end else if (cmd_i.dwell_load_out) begin
          dwell_q <= trans_off_q ? n_out : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ox_q    <= x_q;
      oy_q    <= y_q;
      opos_q  <= count_q;
      olast_q <= cmd_i.last;
      if (cmd_i.kind == EMIT_LEAD_IN) begin
        or_q <= '0;
        og_q <= '0;
        ob_q <= '0;
      end else begin
        or_q <= r_q;
        og_q <= g_q;
        ob_q <= b_q;
      end
      ofl_q <= (cmd_i.kind == EMIT_POINT) ? fl_q : (fl_q | BlankMask);
    end
  end

  assign st_o.full        = (count_q >= limit_q);
  assign st_o.limit_hit   = (count_inc == limit_q);
  assign st_o.dwell_zero  = (dwell_q == '0);
  assign st_o.dwell_one   = (dwell_q == DwellW'(1));
  assign st_o.no_lead_out = !trans_off_q || (n_out == '0);
  assign st_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {opos_q, ofl_q, ob_q, og_q, or_q, oy_q, ox_q};
  assign out_last_o  = olast_q;

  a_emit_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (count_q < limit_q))
    else $error("result emitted at or past the frame limit");

  a_position_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == $past(count_inc)))
    else $error("frame position did not advance on emit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.emit)
    else $error("stalled result overwritten");

endmodule
`default_nettype wire

FILE: hw/rtl/laser_blank_dwell_inserter_core.sv
// Top level of the laser blanking dwell inserter: controller plus datapath.
// The first result of a request is emitted from the lead-in state when a lead-in run
// opens it, else from the point state after the lead-in state; results are registered.
// Throughput: one result per cycle within a run while the output does not stall; the
// lead-in state emits nothing in the step in which it hands over to the point state.
// Input is taken only while the controller is idle; a held result does not block it.
// Reset: controller idle, beam treated as blank, frame count zero, dwell counts zero,
// output limit 65535.
`timescale 1ns / 1ps
`default_nettype none
module laser_blank_dwell_inserter_core #(
  parameter int unsigned MAX_DWELL      = lbdi_pkg::MaxDwell,
  parameter int unsigned COLOR_BITS     = lbdi_pkg::ColorBits,
  parameter int unsigned BLANK_FLAG_BIT = lbdi_pkg::BlankFlagBit
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [lbdi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [lbdi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // pos_x, pos_y, red, green, blue, point_flags
  input  wire  [lbdi_pkg::InDataW-1:0]   s_axis_tdata,
  // frame_start
  input  wire  [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // out_x, out_y, out_red, out_green, out_blue, out_flags, out_position
  output logic [lbdi_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);
  import lbdi_pkg::*;

  lbdi_cmd_t    cmd;
  lbdi_status_t st;

  lbdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lbdi_datapath #(
    .MAX_DWELL      (MAX_DWELL),
    .COLOR_BITS     (COLOR_BITS),
    .BLANK_FLAG_BIT (BLANK_FLAG_BIT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_data_i        (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser[0]),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (m_axis_tdata),
    .out_last_o       (m_axis_tlast)
  );

endmodule
`default_nettype wire
